/* hdl/bilinear_table_interpolator_defines.svh */
// Assertion macros for the bilinear table interpolator.
// Expects clk and rst_n in the scope of use.
`ifndef BILINEAR_TABLE_INTERPOLATOR_DEFINES_SVH
`define BILINEAR_TABLE_INTERPOLATOR_DEFINES_SVH

// same-cycle implication
`define BTI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BTI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/bti_pkg.sv */
// Shared types and constants of the bilinear table interpolator.
// No dependencies; used by bti_frac_div and bilinear_table_interpolator.
`default_nettype none

package bti_pkg;

    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;
    localparam int CNT_W   = 7;
    localparam int FRAC_BITS = 16;
    localparam int FRAC_W  = FRAC_BITS + 1;
    localparam int DIV_W   = 32;

    localparam logic [1:0] ACT_LOAD_ROW  = 2'd0;
    localparam logic [1:0] ACT_LOAD_COL  = 2'd1;
    localparam logic [1:0] ACT_LOAD_GRID = 2'd2;
    localparam logic [1:0] ACT_QUERY     = 2'd3;

    localparam logic [1:0] REG_ROW_COUNT   = 2'd0;
    localparam logic [1:0] REG_COL_COUNT   = 2'd1;
    localparam logic [1:0] REG_TABLE_READY = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BP_FIRST,
        ST_BP_LAST,
        ST_CLASSIFY,
        ST_PROBE,
        ST_COMPARE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_GRID_BASE,
        ST_GRID_RD,
        ST_GRID_LAST,
        ST_LERP_MUL,
        ST_LERP_ADD,
        ST_RESULT
    } state_t;

    typedef enum logic [1:0] {
        MODE_BELOW,
        MODE_ABOVE,
        MODE_SEARCH
    } mode_t;

endpackage

`default_nettype wire

/* hdl/bti_item_if.sv */
// Input channel of the interpolator: load or query items.
// Standalone; no package use.
`default_nettype none

interface bti_item_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic [11:0]        entry_index;
    logic signed [31:0] load_value;
    logic signed [31:0] query_row;
    logic signed [31:0] query_col;

    modport source (output valid, action, entry_index, load_value, query_row, query_col,
                    input ready);
    modport sink (input valid, action, entry_index, load_value, query_row, query_col,
                  output ready);
endinterface

`default_nettype wire

/* hdl/bti_result_if.sv */
// Result channel of the interpolator.
// Standalone; no package use.
`default_nettype none

interface bti_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] interpolated;
    logic               not_ready;

    modport source (output valid, interpolated, not_ready, input ready);
    modport sink (input valid, interpolated, not_ready, output ready);
endinterface

`default_nettype wire

/* hdl/bti_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Standalone.
`default_nettype none

module bti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* hdl/bti_frac_div.sv */
// Radix-2 restoring divider for the Q1.16 fraction num * 2^16 / den, num <= den.
// Uses bti_pkg; after start it computes 16 quotient bits, one per step, then a one-cycle done pulse.
`default_nettype none

module bti_frac_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [bti_pkg::DIV_W-1:0]   num,
    input  wire logic [bti_pkg::DIV_W-1:0]   den,
    output logic                             done,
    output logic      [bti_pkg::FRAC_W-1:0]  quot
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [3:0]                    cnt_reg, cnt_next;
    logic [bti_pkg::DIV_W:0]       rem_reg, rem_next;
    logic [bti_pkg::DIV_W-1:0]     den_reg, den_next;
    logic [bti_pkg::FRAC_W-1:0]    quot_reg, quot_next;
    logic [bti_pkg::DIV_W:0]       shifted;
    logic                          qbit;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        shifted   = {rem_reg[bti_pkg::DIV_W-1:0], 1'b0};
        qbit      = (shifted >= {1'b0, den_reg});
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            den_next  = den;
            if (num >= den)
            begin
                // integer bit set, fraction bits all zero
                quot_next = {1'b1, {bti_pkg::FRAC_BITS{1'b0}}};
                rem_next  = '0;
            end
            else
            begin
                quot_next = '0;
                rem_next  = {1'b0, num};
            end
        end
        else if (busy_reg)
        begin
            rem_next  = qbit ? (shifted - {1'b0, den_reg}) : shifted;
            quot_next = {quot_reg[bti_pkg::FRAC_W-1], quot_reg[bti_pkg::FRAC_BITS-2:0], qbit};
            cnt_next  = cnt_reg + 4'd1;
            if (cnt_reg == 4'(bti_pkg::FRAC_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

`default_nettype wire

/* hdl/bilinear_table_interpolator.sv */
// Load items are accepted only while idle. A query with the table not ready returns zero with
// not_ready set. A ready query runs one breakpoint RAM read per search probe, the 16-step
// fraction divider, four serial grid RAM reads and three multiply/add passes.
// One query at a time; a finished result waits in the output register.
// Reset (rst_n, async): counts 2, table not ready; table RAM contents undefined until written.
`default_nettype none
`include "bilinear_table_interpolator_defines.svh"

module bilinear_table_interpolator #(
    parameter int MAX_ROWS   = 64,
    parameter int MAX_COLS   = 64,
    parameter int VALUE_BITS = 32
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    bti_item_if.sink                         item,
    bti_result_if.source                     result,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [bti_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [bti_pkg::DATA_W-1:0]  pwdata,
    output logic      [bti_pkg::DATA_W-1:0]  prdata,
    output logic                             pready
);

    localparam int RW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_COLS);
    localparam int GD = MAX_ROWS * MAX_COLS;
    localparam int GA = $clog2(GD);
    localparam int SAT_BITS = (VALUE_BITS < 32) ? VALUE_BITS : 32;
    localparam longint SAT_MAX_L = (64'sd1 <<< (SAT_BITS - 1)) - 64'sd1;
    localparam logic signed [31:0] SAT_MAX = 32'(SAT_MAX_L);
    localparam logic signed [31:0] SAT_MIN = 32'(-SAT_MAX_L - 64'sd1);
    localparam logic signed [50:0] ROUND_HALF = 51'sd32768;

    // configuration
    logic [bti_pkg::CNT_W-1:0] row_count_reg, row_count_next;
    logic [bti_pkg::CNT_W-1:0] col_count_reg, col_count_next;
    logic                      ready_flag_reg, ready_flag_next;
    logic                      cfg_wr;
    logic [bti_pkg::CNT_W-1:0] cnt_in;

    // sequencer
    bti_pkg::state_t state_reg, state_next;
    bti_pkg::mode_t  mode_reg [2];
    bti_pkg::mode_t  mode_next [2];
    logic signed [31:0] qx_reg [2];
    logic signed [31:0] qx_next [2];
    logic signed [31:0] bplo_reg [2];
    logic signed [31:0] bplo_next [2];
    logic signed [31:0] bphi_reg [2];
    logic signed [31:0] bphi_next [2];
    logic [RW-1:0] rlo_reg, rlo_next, rhi_reg, rhi_next;
    logic [CW-1:0] clo_reg, clo_next, chi_reg, chi_next;
    logic [bti_pkg::FRAC_W-1:0] frac_reg [2];
    logic [bti_pkg::FRAC_W-1:0] frac_next [2];
    logic [GA-1:0] base_reg [2];
    logic [GA-1:0] base_next [2];
    logic [1:0] gk_reg, gk_next;
    logic [1:0] lk_reg, lk_next;
    logic signed [31:0] p_reg [4];
    logic signed [31:0] p_next [4];
    logic signed [31:0] xp_reg [2];
    logic signed [31:0] xp_next [2];
    logic signed [50:0] prod_reg, prod_next;
    logic signed [31:0] res_reg, res_next;
    logic               nr_reg, nr_next;

    // output stage
    logic               out_valid_reg, out_valid_next;
    logic signed [31:0] out_val_reg, out_val_next;
    logic               out_nr_reg, out_nr_next;

    // memories
    logic          row_we, col_we, grid_we;
    logic [RW-1:0] row_raddr;
    logic [CW-1:0] col_raddr;
    logic [GA-1:0] grid_raddr;
    logic [31:0]   row_rdata, col_rdata, grid_rdata;

    // datapath helpers
    logic [RW:0]   rsum;
    logic [CW:0]   csum;
    logic [RW-1:0] rmid, rnm1, rnm2;
    logic [CW-1:0] cmid, cnm1, cnm2;
    logic          rdone, cdone;
    logic signed [32:0] span [2];
    logic signed [32:0] numv [2];
    logic [bti_pkg::DIV_W-1:0] div_num [2];
    logic [bti_pkg::DIV_W-1:0] div_den [2];
    logic       div_start;
    logic [1:0] div_done;
    logic [bti_pkg::FRAC_W-1:0] div_quot [2];
    logic signed [31:0] lerp_a, lerp_b;
    logic [bti_pkg::FRAC_W-1:0] lerp_f;
    logic signed [32:0] lerp_d;
    logic signed [50:0] rounded;
    logic signed [32:0] lerp_sum;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        row_count_next  = row_count_reg;
        col_count_next  = col_count_reg;
        ready_flag_next = ready_flag_reg;
        cnt_in          = pwdata[bti_pkg::CNT_W-1:0];
        if (cfg_wr)
        begin
            case (paddr[3:2])
                bti_pkg::REG_ROW_COUNT:
                begin
                    if (cnt_in < 7'd2)
                        row_count_next = 7'd2;
                    else if (int'(cnt_in) > MAX_ROWS)
                        row_count_next = 7'(MAX_ROWS);
                    else
                        row_count_next = cnt_in;
                end
                bti_pkg::REG_COL_COUNT:
                begin
                    if (cnt_in < 7'd2)
                        col_count_next = 7'd2;
                    else if (int'(cnt_in) > MAX_COLS)
                        col_count_next = 7'(MAX_COLS);
                    else
                        col_count_next = cnt_in;
                end
                bti_pkg::REG_TABLE_READY:
                begin
                    ready_flag_next = pwdata[0];
                end
                default:
                begin
                    ready_flag_next = ready_flag_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            bti_pkg::REG_ROW_COUNT:   prdata = 32'(row_count_reg);
            bti_pkg::REG_COL_COUNT:   prdata = 32'(col_count_reg);
            bti_pkg::REG_TABLE_READY: prdata = 32'(ready_flag_reg);
            default:                  prdata = '0;
        endcase
    end

    // ---------------- table memories ----------------
    assign item.ready = (state_reg == bti_pkg::ST_IDLE);

    assign row_we  = item.valid && item.ready && (item.action == bti_pkg::ACT_LOAD_ROW)
                     && (int'(item.entry_index) < MAX_ROWS);
    assign col_we  = item.valid && item.ready && (item.action == bti_pkg::ACT_LOAD_COL)
                     && (int'(item.entry_index) < MAX_COLS);
    assign grid_we = item.valid && item.ready && (item.action == bti_pkg::ACT_LOAD_GRID)
                     && (int'(item.entry_index) < GD);

    bti_ram #(.WIDTH(32), .DEPTH(MAX_ROWS)) u_row_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (RW'(item.entry_index)),
        .wdata (item.load_value),
        .raddr (row_raddr),
        .rdata (row_rdata)
    );

    bti_ram #(.WIDTH(32), .DEPTH(MAX_COLS)) u_col_ram (
        .clk   (clk),
        .we    (col_we),
        .waddr (CW'(item.entry_index)),
        .wdata (item.load_value),
        .raddr (col_raddr),
        .rdata (col_rdata)
    );

    bti_ram #(.WIDTH(32), .DEPTH(GD)) u_grid_ram (
        .clk   (clk),
        .we    (grid_we),
        .waddr (GA'(item.entry_index)),
        .wdata (item.load_value),
        .raddr (grid_raddr),
        .rdata (grid_rdata)
    );

    // ---------------- fraction dividers ----------------
    bti_frac_div u_row_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num[0]),
        .den   (div_den[0]),
        .done  (div_done[0]),
        .quot  (div_quot[0])
    );

    bti_frac_div u_col_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num[1]),
        .den   (div_den[1]),
        .done  (div_done[1]),
        .quot  (div_quot[1])
    );

    // ---------------- search helpers ----------------
    assign rsum  = {1'b0, rlo_reg} + {1'b0, rhi_reg};
    assign csum  = {1'b0, clo_reg} + {1'b0, chi_reg};
    assign rmid  = rsum[RW:1];
    assign cmid  = csum[CW:1];
    assign rnm1  = RW'(int'(row_count_reg) - 1);
    assign rnm2  = RW'(int'(row_count_reg) - 2);
    assign cnm1  = CW'(int'(col_count_reg) - 1);
    assign cnm2  = CW'(int'(col_count_reg) - 2);
    assign rdone = ((rhi_reg - rlo_reg) <= RW'(1));
    assign cdone = ((chi_reg - clo_reg) <= CW'(1));

    // divider operands; clamped axes are folded into 0/1 or 1/1
    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            span[k] = {bphi_reg[k][31], bphi_reg[k]} - {bplo_reg[k][31], bplo_reg[k]};
            numv[k] = {qx_reg[k][31], qx_reg[k]} - {bplo_reg[k][31], bplo_reg[k]};
            if (mode_reg[k] == bti_pkg::MODE_BELOW)
            begin
                div_num[k] = '0;
                div_den[k] = 32'd1;
            end
            else if (mode_reg[k] == bti_pkg::MODE_ABOVE)
            begin
                div_num[k] = 32'd1;
                div_den[k] = 32'd1;
            end
            else if (span[k] <= 33'sd0)
            begin
                div_num[k] = '0;
                div_den[k] = 32'd1;
            end
            else
            begin
                div_den[k] = span[k][31:0];
                if (numv[k] < 33'sd0)
                    div_num[k] = '0;
                else if (numv[k] > span[k])
                    div_num[k] = span[k][31:0];
                else
                    div_num[k] = numv[k][31:0];
            end
        end
    end

    // ---------------- shared lerp datapath ----------------
    always_comb
    begin
        case (lk_reg)
            2'd0:
            begin
                lerp_a = p_reg[0];
                lerp_b = p_reg[2];
                lerp_f = frac_reg[0];
            end
            2'd1:
            begin
                lerp_a = p_reg[1];
                lerp_b = p_reg[3];
                lerp_f = frac_reg[0];
            end
            default:
            begin
                lerp_a = xp_reg[0];
                lerp_b = xp_reg[1];
                lerp_f = frac_reg[1];
            end
        endcase
    end

    assign lerp_d   = {lerp_b[31], lerp_b} - {lerp_a[31], lerp_a};
    // round half up, then floor shift
    assign rounded  = (prod_reg + ROUND_HALF) >>> bti_pkg::FRAC_BITS;
    assign lerp_sum = {lerp_a[31], lerp_a} + rounded[32:0];

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        qx_next        = qx_reg;
        bplo_next      = bplo_reg;
        bphi_next      = bphi_reg;
        rlo_next       = rlo_reg;
        rhi_next       = rhi_reg;
        clo_next       = clo_reg;
        chi_next       = chi_reg;
        frac_next      = frac_reg;
        base_next      = base_reg;
        gk_next        = gk_reg;
        lk_next        = lk_reg;
        p_next         = p_reg;
        xp_next        = xp_reg;
        prod_next      = prod_reg;
        res_next       = res_reg;
        nr_next        = nr_reg;
        out_valid_next = out_valid_reg;
        out_val_next   = out_val_reg;
        out_nr_next    = out_nr_reg;
        row_raddr      = '0;
        col_raddr      = '0;
        grid_raddr     = '0;
        div_start      = 1'b0;

        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            bti_pkg::ST_IDLE:
            begin
                if (item.valid && (item.action == bti_pkg::ACT_QUERY))
                begin
                    if (ready_flag_reg)
                    begin
                        qx_next[0] = item.query_row;
                        qx_next[1] = item.query_col;
                        state_next = bti_pkg::ST_BP_FIRST;
                    end
                    else
                    begin
                        res_next   = '0;
                        nr_next    = 1'b1;
                        state_next = bti_pkg::ST_RESULT;
                    end
                end
            end
            bti_pkg::ST_BP_FIRST:
            begin
                state_next = bti_pkg::ST_BP_LAST;
            end
            bti_pkg::ST_BP_LAST:
            begin
                row_raddr    = rnm1;
                col_raddr    = cnm1;
                bplo_next[0] = $signed(row_rdata);
                bplo_next[1] = $signed(col_rdata);
                state_next   = bti_pkg::ST_CLASSIFY;
            end
            bti_pkg::ST_CLASSIFY:
            begin
                // row_rdata / col_rdata hold the last breakpoints now
                if (qx_reg[0] <= bplo_reg[0])
                begin
                    mode_next[0] = bti_pkg::MODE_BELOW;
                    rlo_next     = '0;
                    rhi_next     = RW'(1);
                end
                else if (qx_reg[0] >= $signed(row_rdata))
                begin
                    mode_next[0] = bti_pkg::MODE_ABOVE;
                    rlo_next     = rnm2;
                    rhi_next     = rnm1;
                end
                else
                begin
                    mode_next[0] = bti_pkg::MODE_SEARCH;
                    rlo_next     = '0;
                    rhi_next     = rnm1;
                    bphi_next[0] = $signed(row_rdata);
                end
                if (qx_reg[1] <= bplo_reg[1])
                begin
                    mode_next[1] = bti_pkg::MODE_BELOW;
                    clo_next     = '0;
                    chi_next     = CW'(1);
                end
                else if (qx_reg[1] >= $signed(col_rdata))
                begin
                    mode_next[1] = bti_pkg::MODE_ABOVE;
                    clo_next     = cnm2;
                    chi_next     = cnm1;
                end
                else
                begin
                    mode_next[1] = bti_pkg::MODE_SEARCH;
                    clo_next     = '0;
                    chi_next     = cnm1;
                    bphi_next[1] = $signed(col_rdata);
                end
                state_next = bti_pkg::ST_PROBE;
            end
            bti_pkg::ST_PROBE:
            begin
                row_raddr = rmid;
                col_raddr = cmid;
                if (rdone && cdone)
                    state_next = bti_pkg::ST_DIV_START;
                else
                    state_next = bti_pkg::ST_COMPARE;
            end
            bti_pkg::ST_COMPARE:
            begin
                if (!rdone)
                begin
                    if (qx_reg[0] < $signed(row_rdata))
                    begin
                        rhi_next     = rmid;
                        bphi_next[0] = $signed(row_rdata);
                    end
                    else
                    begin
                        rlo_next     = rmid;
                        bplo_next[0] = $signed(row_rdata);
                    end
                end
                if (!cdone)
                begin
                    if (qx_reg[1] < $signed(col_rdata))
                    begin
                        chi_next     = cmid;
                        bphi_next[1] = $signed(col_rdata);
                    end
                    else
                    begin
                        clo_next     = cmid;
                        bplo_next[1] = $signed(col_rdata);
                    end
                end
                state_next = bti_pkg::ST_PROBE;
            end
            bti_pkg::ST_DIV_START:
            begin
                div_start  = 1'b1;
                state_next = bti_pkg::ST_DIV_WAIT;
            end
            bti_pkg::ST_DIV_WAIT:
            begin
                if (div_done[0])
                begin
                    frac_next[0] = div_quot[0];
                    frac_next[1] = div_quot[1];
                    state_next   = bti_pkg::ST_GRID_BASE;
                end
            end
            bti_pkg::ST_GRID_BASE:
            begin
                base_next[0] = GA'(rlo_reg) * GA'(col_count_reg);
                base_next[1] = GA'(rhi_reg) * GA'(col_count_reg);
                gk_next      = '0;
                state_next   = bti_pkg::ST_GRID_RD;
            end
            bti_pkg::ST_GRID_RD:
            begin
                // corner order: (lo,lo) (lo,hi) (hi,lo) (hi,hi)
                grid_raddr = base_reg[gk_reg[1]] + (gk_reg[0] ? GA'(chi_reg) : GA'(clo_reg));
                if (gk_reg != 2'd0)
                begin
                    p_next[gk_reg - 2'd1] = $signed(grid_rdata);
                end
                gk_next = gk_reg + 2'd1;
                if (gk_reg == 2'd3)
                    state_next = bti_pkg::ST_GRID_LAST;
            end
            bti_pkg::ST_GRID_LAST:
            begin
                p_next[3]  = $signed(grid_rdata);
                lk_next    = '0;
                state_next = bti_pkg::ST_LERP_MUL;
            end
            bti_pkg::ST_LERP_MUL:
            begin
                prod_next  = lerp_d * $signed({1'b0, lerp_f});
                state_next = bti_pkg::ST_LERP_ADD;
            end
            bti_pkg::ST_LERP_ADD:
            begin
                case (lk_reg)
                    2'd0:    xp_next[0] = lerp_sum[31:0];
                    2'd1:    xp_next[1] = lerp_sum[31:0];
                    default: res_next   = lerp_sum[31:0];
                endcase
                if (lk_reg == 2'd2)
                begin
                    nr_next    = 1'b0;
                    state_next = bti_pkg::ST_RESULT;
                end
                else
                begin
                    lk_next    = lk_reg + 2'd1;
                    state_next = bti_pkg::ST_LERP_MUL;
                end
            end
            bti_pkg::ST_RESULT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_nr_next    = nr_reg;
                    if (res_reg > SAT_MAX)
                        out_val_next = SAT_MAX;
                    else if (res_reg < SAT_MIN)
                        out_val_next = SAT_MIN;
                    else
                        out_val_next = res_reg;
                    state_next = bti_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bti_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= bti_pkg::ST_IDLE;
            row_count_reg  <= 7'd2;
            col_count_reg  <= 7'd2;
            ready_flag_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            gk_reg         <= '0;
            lk_reg         <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            row_count_reg  <= row_count_next;
            col_count_reg  <= col_count_next;
            ready_flag_reg <= ready_flag_next;
            out_valid_reg  <= out_valid_next;
            gk_reg         <= gk_next;
            lk_reg         <= lk_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg    <= mode_next;
        qx_reg      <= qx_next;
        bplo_reg    <= bplo_next;
        bphi_reg    <= bphi_next;
        rlo_reg     <= rlo_next;
        rhi_reg     <= rhi_next;
        clo_reg     <= clo_next;
        chi_reg     <= chi_next;
        frac_reg    <= frac_next;
        base_reg    <= base_next;
        p_reg       <= p_next;
        xp_reg      <= xp_next;
        prod_reg    <= prod_next;
        res_reg     <= res_next;
        nr_reg      <= nr_next;
        out_val_reg <= out_val_next;
        out_nr_reg  <= out_nr_next;
    end

    assign result.valid        = out_valid_reg;
    assign result.interpolated = out_val_reg;
    assign result.not_ready    = out_nr_reg;

    // ---------------- assertions ----------------
    `BTI_ASSERT_NOW(a_div_lockstep, 1'b1, div_done[0] == div_done[1],
        "row and column dividers out of step")
    `BTI_ASSERT_NOW(a_count_range, 1'b1,
        (row_count_reg >= 7'd2) && (int'(row_count_reg) <= MAX_ROWS)
        && (col_count_reg >= 7'd2) && (int'(col_count_reg) <= MAX_COLS),
        "breakpoint count out of range")
    `BTI_ASSERT_NOW(a_bracket_order, state_reg == bti_pkg::ST_PROBE,
        (rlo_reg < rhi_reg) && (clo_reg < chi_reg),
        "search bracket collapsed")
    `BTI_ASSERT_NEXT(a_frac_bound, state_reg == bti_pkg::ST_DIV_WAIT && div_done[0],
        (frac_reg[0] <= 17'h10000) && (frac_reg[1] <= 17'h10000),
        "fraction above one")

endmodule

`default_nettype wire
